// ===== src/gnc_pkg.sv =====
// Shared types, codes and offset tables of the grid neighbour cell lister.
`timescale 1ns / 1ps
package gnc_pkg;

  // Map limits and fixed field widths
  localparam int MAX_WIDTH_DEF  = 256;
  localparam int MAX_HEIGHT_DEF = 256;
  localparam int DIM_W          = 9;   // width of grid_width / grid_height
  localparam int IDX_W          = 16;  // cell index width
  localparam int COL_W          = 8;   // column always below 256
  localparam int DIV_STAGES     = 4;   // quotient bits split over these stages
  localparam int NSLOT          = 9;   // offset table entries

  // Commands
  typedef enum logic [1:0] {
    CMD_AREA  = 2'd0,
    CMD_ENTER = 2'd1,
    CMD_LEAVE = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  // Register indexes (byte address bit 2)
  localparam logic REG_GRID_WIDTH  = 1'b0;
  localparam logic REG_GRID_HEIGHT = 1'b1;

  // Neighbour offsets, y grows downward, centre last
  localparam logic signed [1:0] NB_DX [NSLOT] = '{
    2'sd0, 2'sd1, 2'sd1, 2'sd1, 2'sd0, -2'sd1, -2'sd1, -2'sd1, 2'sd0};
  localparam logic signed [1:0] NB_DY [NSLOT] = '{
    -2'sd1, -2'sd1, 2'sd0, 2'sd1, 2'sd1, 2'sd1, 2'sd0, -2'sd1, 2'sd0};

  // Slot ranges of the move lists, slot = (i + direction) mod 8
  localparam logic [3:0] ENTER_LO_ODD  = 4'd6;
  localparam logic [3:0] ENTER_HI_ODD  = 4'd10;
  localparam logic [3:0] ENTER_LO_EVEN = 4'd7;
  localparam logic [3:0] ENTER_HI_EVEN = 4'd9;
  localparam logic [3:0] LEAVE_LO_ODD  = 4'd2;
  localparam logic [3:0] LEAVE_HI_ODD  = 4'd6;
  localparam logic [3:0] LEAVE_LO_EVEN = 4'd3;
  localparam logic [3:0] LEAVE_HI_EVEN = 4'd5;

  // Input item
  typedef struct packed {
    cmd_e             cmd;
    logic [IDX_W-1:0] cell_index;
    logic [2:0]       direction;
  } in_t;

  // Result item
  typedef struct packed {
    logic [IDX_W-1:0] neighbour_index;
    logic             last;
    logic             empty_res;
    logic             error;
  } out_t;

  // Item after the column/row split
  typedef struct packed {
    cmd_e             cmd;
    logic [2:0]       direction;
    logic [IDX_W-1:0] cell_index;
    logic [COL_W-1:0] col;
    logic [IDX_W-1:0] row;
    logic             err;
  } split_t;

endpackage

// ===== src/gnc_cfg.sv =====
// APB-style register block holding the grid width and height.
`timescale 1ns / 1ps
module gnc_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output logic [gnc_pkg::DIM_W-1:0]   grid_width,
  output logic [gnc_pkg::DIM_W-1:0]   grid_height
);

  logic [gnc_pkg::DIM_W-1:0] width_r;
  logic [gnc_pkg::DIM_W-1:0] height_r;
  logic                      wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= gnc_pkg::DIM_W'(256);
      height_r <= gnc_pkg::DIM_W'(256);
    end else if (wr_en) begin
      case (paddr[2])
        gnc_pkg::REG_GRID_WIDTH:  width_r  <= pwdata[gnc_pkg::DIM_W-1:0];
        gnc_pkg::REG_GRID_HEIGHT: height_r <= pwdata[gnc_pkg::DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    case (paddr[2])
      gnc_pkg::REG_GRID_WIDTH:  prdata = {{(32-gnc_pkg::DIM_W){1'b0}}, width_r};
      gnc_pkg::REG_GRID_HEIGHT: prdata = {{(32-gnc_pkg::DIM_W){1'b0}}, height_r};
      default:                  prdata = '0;
    endcase
  end

  assign grid_width  = width_r;
  assign grid_height = height_r;

endmodule

// ===== src/gnc_divider.sv =====
// Pipelined restoring divider splitting the cell index into row and column.
`timescale 1ns / 1ps
module gnc_divider (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  gnc_pkg::in_t              in_item,
  input  logic [gnc_pkg::DIM_W-1:0] w_eff,
  input  logic [gnc_pkg::DIM_W-1:0] h_eff,
  output logic                      dn_valid,
  input  logic                      dn_ready,
  output gnc_pkg::split_t           dn_item
);

  localparam int NS  = gnc_pkg::DIV_STAGES;
  localparam int QW  = gnc_pkg::IDX_W;
  localparam int BPS = QW / NS;
  localparam int CW  = gnc_pkg::COL_W;

  logic             v_r    [0:NS];
  gnc_pkg::in_t     item_r [0:NS];
  logic [QW-1:0]    num_r  [0:NS];   // dividend bits still to go, quotient shifted in
  logic [CW-1:0]    rem_r  [0:NS];
  logic             err_r  [1:NS];
  logic             rdy    [0:NS];
  logic [QW-1:0]    num_nxt [1:NS];
  logic [CW-1:0]    rem_nxt [1:NS];
  logic [2*gnc_pkg::DIM_W-1:0] cells;
  logic             err_nxt;

  // A stage loads when empty or when its item moves on
  always_comb begin
    rdy[NS] = !v_r[NS] || dn_ready;
    for (int j = NS - 1; j >= 0; j--) begin
      rdy[j] = !v_r[j] || rdy[j+1];
    end
  end
  assign in_ready = rdy[0];

  // Map bounds check beside the first divide stage
  assign cells   = (2*gnc_pkg::DIM_W)'(w_eff) * (2*gnc_pkg::DIM_W)'(h_eff);
  assign err_nxt = (2*gnc_pkg::DIM_W)'(item_r[0].cell_index) >= cells;

  // BPS restoring steps per stage
  always_comb begin
    logic [QW-1:0] num;
    logic [CW-1:0] rem;
    logic [CW:0]   trial;
    for (int j = 1; j <= NS; j++) begin
      num = num_r[j-1];
      rem = rem_r[j-1];
      for (int b = 0; b < BPS; b++) begin
        trial = {rem, num[QW-1]};
        num   = {num[QW-2:0], 1'b0};
        if (trial >= w_eff) begin
          rem    = CW'(trial - w_eff);
          num[0] = 1'b1;
        end else begin
          rem = CW'(trial);
        end
      end
      num_nxt[j] = num;
      rem_nxt[j] = rem;
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j <= NS; j++) v_r[j] <= 1'b0;
    end else begin
      if (rdy[0]) v_r[0] <= in_valid;
      for (int j = 1; j <= NS; j++) begin
        if (rdy[j]) v_r[j] <= v_r[j-1];
      end
    end
  end

  // Stage payload
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      item_r[0] <= in_item;
      num_r[0]  <= in_item.cell_index;
      rem_r[0]  <= '0;
    end
    if (rdy[1]) err_r[1] <= err_nxt;
    for (int j = 2; j <= NS; j++) begin
      if (rdy[j]) err_r[j] <= err_r[j-1];
    end
    for (int j = 1; j <= NS; j++) begin
      if (rdy[j]) begin
        item_r[j] <= item_r[j-1];
        num_r[j]  <= num_nxt[j];
        rem_r[j]  <= rem_nxt[j];
      end
    end
  end

  // Handoff
  assign dn_valid             = v_r[NS];
  assign dn_item.cmd          = item_r[NS].cmd;
  assign dn_item.direction    = item_r[NS].direction;
  assign dn_item.cell_index   = item_r[NS].cell_index;
  assign dn_item.col          = rem_r[NS];
  assign dn_item.row          = num_r[NS];
  assign dn_item.err          = err_r[NS];

endmodule

// ===== src/gnc_emitter.sv =====
// Builds the cell list of one item and sends it out one result per cycle while out_ready is high.
`timescale 1ns / 1ps
module gnc_emitter (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      up_valid,
  output logic                      up_ready,
  input  gnc_pkg::split_t           up_item,
  input  logic [gnc_pkg::DIM_W-1:0] w_eff,
  input  logic [gnc_pkg::DIM_W-1:0] h_eff,
  output logic                      out_valid,
  input  logic                      out_ready,
  output gnc_pkg::out_t             out_data
);

  localparam int NSL = gnc_pkg::NSLOT;
  localparam int IW  = gnc_pkg::IDX_W;

  logic [IW-1:0]  slot_idx [NSL];
  logic           slot_ok  [NSL];
  logic [IW-1:0]  list_idx [NSL];
  logic [NSL-1:0] list_ok;

  logic           hold_v_r;
  logic           hold_err_r;
  logic [NSL-1:0] hold_mask_r;
  logic [IW-1:0]  hold_idx_r [NSL];

  logic           out_valid_r;
  gnc_pkg::out_t  out_data_r;

  logic [3:0]     pos;
  logic [NSL-1:0] rest;
  gnc_pkg::out_t  cur;
  logic           out_load;
  logic           done;

  // Candidate cells around the centre
  always_comb begin
    logic          left_ok, right_ok, up_ok, down_ok;
    logic [IW-1:0] row_up, row_dn, base;
    logic          ok_y;
    left_ok  = up_item.col != '0;
    right_ok = (gnc_pkg::DIM_W'(up_item.col) + gnc_pkg::DIM_W'(1)) < w_eff;
    up_ok    = up_item.row != '0;
    down_ok  = ((IW+1)'(up_item.row) + (IW+1)'(1)) < (IW+1)'(h_eff);
    row_up   = up_item.cell_index - IW'(w_eff);
    row_dn   = up_item.cell_index + IW'(w_eff);
    for (int k = 0; k < NSL; k++) begin
      if (gnc_pkg::NB_DY[k] == -2'sd1) begin
        base = row_up;
        ok_y = up_ok;
      end else if (gnc_pkg::NB_DY[k] == 2'sd1) begin
        base = row_dn;
        ok_y = down_ok;
      end else begin
        base = up_item.cell_index;
        ok_y = 1'b1;
      end
      if (gnc_pkg::NB_DX[k] == -2'sd1) begin
        slot_idx[k] = base - IW'(1);
        slot_ok[k]  = ok_y && left_ok;
      end else if (gnc_pkg::NB_DX[k] == 2'sd1) begin
        slot_idx[k] = base + IW'(1);
        slot_ok[k]  = ok_y && right_ok;
      end else begin
        slot_idx[k] = base;
        slot_ok[k]  = ok_y;
      end
    end
  end

  // Order the candidates by command and direction
  always_comb begin
    logic [3:0] lo, hi;
    logic [3:0] s;
    logic       moving;
    lo     = '0;
    hi     = '0;
    moving = 1'b0;
    for (int p = 0; p < NSL; p++) begin
      list_idx[p] = slot_idx[p];
      list_ok[p]  = 1'b0;
    end
    case (up_item.cmd)
      gnc_pkg::CMD_AREA: begin
        for (int p = 0; p < NSL; p++) list_ok[p] = slot_ok[p];
      end
      gnc_pkg::CMD_ENTER: begin
        moving = 1'b1;
        lo = up_item.direction[0] ? gnc_pkg::ENTER_LO_ODD : gnc_pkg::ENTER_LO_EVEN;
        hi = up_item.direction[0] ? gnc_pkg::ENTER_HI_ODD : gnc_pkg::ENTER_HI_EVEN;
      end
      gnc_pkg::CMD_LEAVE: begin
        moving = 1'b1;
        lo = up_item.direction[0] ? gnc_pkg::LEAVE_LO_ODD : gnc_pkg::LEAVE_LO_EVEN;
        hi = up_item.direction[0] ? gnc_pkg::LEAVE_HI_ODD : gnc_pkg::LEAVE_HI_EVEN;
      end
      default: ;
    endcase
    if (moving) begin
      for (int p = 0; p < 5; p++) begin
        // ring slot only, the centre never appears in a move list
        s           = {1'b0, 3'(lo + 4'(p) + 4'(up_item.direction))};
        list_idx[p] = slot_idx[s];
        list_ok[p]  = (4'(p) <= (hi - lo)) && slot_ok[s];
      end
    end
  end

  // First pending list entry
  always_comb begin
    pos = '0;
    for (int k = NSL - 1; k >= 0; k--) begin
      if (hold_mask_r[k]) pos = 4'(k);
    end
    rest = hold_mask_r & ~(NSL'(1) << pos);
  end

  // Result for this cycle
  always_comb begin
    cur = '0;
    if (hold_err_r) begin
      cur.last  = 1'b1;
      cur.error = 1'b1;
    end else if (hold_mask_r == '0) begin
      cur.last      = 1'b1;
      cur.empty_res = 1'b1;
    end else begin
      cur.neighbour_index = hold_idx_r[pos];
      cur.last            = rest == '0;
    end
  end

  assign out_load = hold_v_r && (!out_valid_r || out_ready);
  assign done     = out_load && cur.last;
  assign up_ready = !hold_v_r || done;

  // Hold register control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
    end else if (up_ready) begin
      hold_v_r <= up_valid;
    end
  end

  // Hold register payload
  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      hold_err_r  <= up_item.err;
      hold_mask_r <= up_item.err ? '0 : list_ok;
      for (int p = 0; p < NSL; p++) hold_idx_r[p] <= list_idx[p];
    end else if (out_load) begin
      hold_mask_r <= rest;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) out_data_r <= cur;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== src/grid_neighbour_cell_lister.sv =====
// Top level of the grid neighbour cell lister.
//
// Each input item names a centre cell by linear index, a command and a move
// direction. The block lists the nine-cell neighbourhood, or the cells entered
// or left by that move, as a stream of result items; cells off the map are
// skipped and the final result of an item carries last. An empty list gives
// one result with empty_res, an index outside the map one result with error.
// Channels: in_* and out_* use valid/ready; grid_width and grid_height sit on
// the APB-style port at byte addresses 0 and 4. The user must write them only
// while idle; the block itself does not enforce this. The first result of an
// item passes the input register, four divide stages, the list hold register
// and the output register before it shows on out_valid. Throughput: one result
// per cycle while out_ready is high; an item gives 1 to 9 results, and items
// overlap in the divide pipeline while earlier results drain.
// Reset: synchronous active-low; clears all valid bits and sets both
// dimensions to 256. When out_ready is low the output holds and the stages
// behind it fill, then in_ready drops; nothing is lost or repeated.
`timescale 1ns / 1ps
module grid_neighbour_cell_lister #(
  parameter int MAX_WIDTH  = gnc_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = gnc_pkg::MAX_HEIGHT_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  gnc_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output gnc_pkg::out_t out_data,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  logic [gnc_pkg::DIM_W-1:0] grid_width;
  logic [gnc_pkg::DIM_W-1:0] grid_height;
  logic [gnc_pkg::DIM_W-1:0] w_eff;
  logic [gnc_pkg::DIM_W-1:0] h_eff;
  logic                      split_valid;
  logic                      split_ready;
  gnc_pkg::split_t           split_item;

  gnc_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .grid_width  (grid_width),
    .grid_height (grid_height)
  );

  // Oversized dimensions saturate at the map limits
  assign w_eff = (grid_width > gnc_pkg::DIM_W'(MAX_WIDTH)) ?
                 gnc_pkg::DIM_W'(MAX_WIDTH) : grid_width;
  assign h_eff = (grid_height > gnc_pkg::DIM_W'(MAX_HEIGHT)) ?
                 gnc_pkg::DIM_W'(MAX_HEIGHT) : grid_height;

  gnc_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_data),
    .w_eff    (w_eff),
    .h_eff    (h_eff),
    .dn_valid (split_valid),
    .dn_ready (split_ready),
    .dn_item  (split_item)
  );

  gnc_emitter u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (split_valid),
    .up_ready  (split_ready),
    .up_item   (split_item),
    .w_eff     (w_eff),
    .h_eff     (h_eff),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== src/gnc_checker.sv =====
// Port-level assertions for the grid neighbour cell lister, bound to the top level.
`timescale 1ns / 1ps
module gnc_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          out_valid,
  input logic          out_ready,
  input gnc_pkg::out_t out_data,
  input logic          psel,
  input logic          penable,
  input logic          pwrite,
  input logic [2:0]    paddr,
  input logic [31:0]   pwdata,
  input logic [31:0]   prdata,
  input logic          pready
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // An error result stands alone
  a_err_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.error |->
      out_data.last && !out_data.empty_res && out_data.neighbour_index == '0)
    else $error("malformed error result");

  // An empty result stands alone
  a_empty_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.empty_res |->
      out_data.last && !out_data.error && out_data.neighbour_index == '0)
    else $error("malformed empty result");

  // Nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Register readback after a write
  a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
    psel && penable && pwrite && pready ##1 psel && !pwrite && $stable(paddr) |->
      prdata[8:0] == $past(pwdata[8:0]))
    else $error("register readback mismatch");

endmodule

bind grid_neighbour_cell_lister gnc_checker u_gnc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data),
  .psel      (psel),
  .penable   (penable),
  .pwrite    (pwrite),
  .paddr     (paddr),
  .pwdata    (pwdata),
  .prdata    (prdata),
  .pready    (pready)
);
